// ===== rtl/core/pls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Action and status codes and the per-cycle command that the controller
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package pls_pkg;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_INS_AT    = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_SEARCH    = 3'd6,
    ACT_SORT      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Operation applied by every cell in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD     = 3'd0,
    CELL_INSERT   = 3'd1,
    CELL_REMOVE   = 3'd2,
    CELL_SORT_EVN = 3'd3,
    CELL_SORT_ODD = 3'd4
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SORT = 2'd1,
    S_OUT  = 2'd2
  } state_t;

endpackage

// ===== rtl/core/positional_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed values with positional edits
// A chain of DEPTH cells that shift together on insert and delete, search
// by a parallel compare, and sort by odd-even transposition passes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                         | tuser
//  s_axis  | in  | action[2:0], item_value[31:0], position[4:0]  | -
//  m_axis  | out | status[2:0], value_out[31:0],                 | -
//          |     | found_position, element_count (POS_W each)    |
//
// Insert, delete and search are applied on acceptance; their result is registered for the output beat.
// Sort takes DEPTH transposition passes, one per cycle, plus the result beat.
// One item is in flight at a time; a stalled result holds the next item off.
// Reset clears the count, state and pass counter only; cell contents are undefined until written.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // action[2:0], item_value[34:3], position[3+32+POS_W-1:35]
  input  logic [((3 + 32 + $clog2(DEPTH + 2) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[2:0], value_out[34:3], found_position, element_count
  output logic [((3 + 32 + 2 * $clog2(DEPTH + 2) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = $clog2(DEPTH + 2);
  localparam int TDO_W = ((3 + 32 + 2 * POS_W + 7) / 8) * 8;

  state_t state, state_next;
  cell_op_t op;
  logic [IDX_W-1:0] target;
  logic [POS_W-1:0] count, count_next;
  logic [POS_W-1:0] pass, pass_next;
  logic [31:0] vals [DEPTH];
  logic [DEPTH-1:0] lives, hits;

  logic [2:0] r_status;
  logic [31:0] r_value;
  logic [POS_W-1:0] r_fpos;

  action_t act;
  logic [31:0] ival;
  logic [POS_W-1:0] ipos;
  logic accept;

  assign act  = action_t'(s_axis_tdata[2:0]);
  assign ival = s_axis_tdata[34:3];
  assign ipos = s_axis_tdata[35 +: POS_W];
  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = TDO_W'({count, r_fpos, r_value, r_status});

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign lives[g] = (POS_W'(g) < count);
      assign hits[g]  = lives[g] && (vals[g] == ival);
      pls_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(g))) u_cell (
        .clk(clk), .op(op), .target(target), .ins_value(ival),
        .prev_value((g == 0) ? vals[0] : vals[(g == 0) ? 0 : g - 1]),
        .next_value(vals[(g == DEPTH - 1) ? g : g + 1]),
        .next_live((g == DEPTH - 1) ? 1'b0 : lives[(g == DEPTH - 1) ? g : g + 1]),
        .prev_live((g == 0) ? 1'b0 : lives[(g == 0) ? 0 : g - 1]),
        .live(lives[g]), .value(vals[g])
      );
    end
  endgenerate

  // First match by priority scan over the compare flags.
  logic [POS_W-1:0] first_hit;
  always_comb begin
    first_hit = '0;
    for (int k = DEPTH - 1; k >= 0; k--)
      if (hits[k]) first_hit = POS_W'(k + 1);
  end

  logic [31:0] sel_value;
  logic [2:0]  status_c;
  logic [31:0] value_c;
  logic [POS_W-1:0] fpos_c;

  always_comb begin
    op = CELL_HOLD;
    target = '0;
    count_next = count;
    status_c = ST_OK;
    value_c = '0;
    fpos_c = '0;
    sel_value = vals[target];
    if (accept) begin
      unique case (act)
        ACT_INS_FRONT, ACT_INS_BACK: begin
          if (count >= POS_W'(DEPTH)) status_c = ST_FULL;
          else begin
            op = CELL_INSERT;
            target = (act == ACT_INS_FRONT) ? '0 : count[IDX_W-1:0];
            count_next = count + 1'b1;
          end
        end
        ACT_DEL_FRONT, ACT_DEL_BACK: begin
          if (count == '0) status_c = ST_EMPTY;
          else begin
            op = CELL_REMOVE;
            target = (act == ACT_DEL_FRONT) ? '0 : IDX_W'(count - 1'b1);
            count_next = count - 1'b1;
          end
        end
        ACT_INS_AT: begin
          if (ipos == '0 || ipos > count + 1'b1) status_c = ST_BADPOS;
          else if (count >= POS_W'(DEPTH)) status_c = ST_FULL;
          else begin
            op = CELL_INSERT;
            target = IDX_W'(ipos - 1'b1);
            count_next = count + 1'b1;
          end
        end
        ACT_DEL_AT: begin
          if (count == '0) status_c = ST_EMPTY;
          else if (ipos == '0 || ipos > count) status_c = ST_BADPOS;
          else begin
            op = CELL_REMOVE;
            target = IDX_W'(ipos - 1'b1);
            count_next = count - 1'b1;
          end
        end
        ACT_SEARCH: begin
          if (count == '0) status_c = ST_EMPTY;
          else if (first_hit == '0) status_c = ST_NOTFOUND;
          else begin
            value_c = ival;
            fpos_c = first_hit;
          end
        end
        ACT_SORT: begin
          if (count == '0) status_c = ST_EMPTY;
        end
        default: status_c = ST_OK;
      endcase
      sel_value = vals[target];
      if (op == CELL_REMOVE) value_c = sel_value;
    end else if (state == S_SORT) begin
      op = pass[0] ? CELL_SORT_ODD : CELL_SORT_EVN;
    end
  end

  always_comb begin
    state_next = state;
    pass_next = pass;
    unique case (state)
      S_IDLE: if (accept) begin
        if (act == ACT_SORT && count != '0) begin
          state_next = S_SORT;
          pass_next = '0;
        end else state_next = S_OUT;
      end
      S_SORT: begin
        pass_next = pass + 1'b1;
        if (pass == POS_W'(DEPTH - 1)) state_next = S_OUT;
      end
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pass <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      pass <= pass_next;
    end
    if (accept) begin
      r_status <= status_c;
      r_value <= value_c;
      r_fpos <= fpos_c;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= POS_W'(DEPTH)) else $error("count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> (count == $past(count))) else $error("count moved while busy");
  a_sort_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT && pass == POS_W'(DEPTH - 1)) |=> state == S_OUT)
    else $error("sort did not finish");

endmodule

// ===== rtl/core/pls_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list chain
// Holds one value; shifts toward or away from its neighbors on insert and
// remove, and takes part in odd-even transposition during a sort.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [IDX_W-1:0]  target,
  input  logic [31:0]       ins_value,
  input  logic [31:0]       prev_value,
  input  logic [31:0]       next_value,
  input  logic              next_live,
  input  logic              prev_live,
  input  logic              live,
  output logic [31:0]       value
);

  logic [31:0] value_next;
  logic        pair_low;

  // In an even pass pairs start at even indices, in an odd pass at odd ones.
  assign pair_low = (op == CELL_SORT_EVN) ? ~INDEX[0] : INDEX[0];

  always_comb begin
    value_next = value;
    unique case (op)
      CELL_INSERT: begin
        if (INDEX == target) value_next = ins_value;
        else if (INDEX > target) value_next = prev_value;
      end
      CELL_REMOVE: begin
        if (INDEX >= target) value_next = next_value;
      end
      CELL_SORT_EVN, CELL_SORT_ODD: begin
        if (pair_low) begin
          if (live && next_live && $signed(value) > $signed(next_value))
            value_next = next_value;
        end else begin
          if (live && prev_live && $signed(prev_value) > $signed(value))
            value_next = prev_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
